FILE: design/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg: shared definitions for the modular exponentiation block
// Fixed result width and the controller state codes.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of the result field on the output channel
  localparam int RESULT_WIDTH = 31;

  // Controller state codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_REDUCE  = 3'd1;
  localparam logic [2:0] ST_STEP    = 3'd2;
  localparam logic [2:0] ST_MUL_ACC = 3'd3;
  localparam logic [2:0] ST_SQUARE  = 3'd4;
  localparam logic [2:0] ST_FINISH  = 3'd5;

endpackage

FILE: design/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Interleaved shift-and-add, one multiplier bit per cycle, MSB first.
// Computes (multiplicand * multiplier) mod modulus in WIDTH steps; done
// pulses when the last step is registered.
// Requires multiplicand <= modulus and modulus nonzero.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] multiplicand,
  input  logic [WIDTH-1:0] multiplier,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_m;
  logic [WIDTH-1:0] mplier;
  logic [WIDTH-1:0] acc;

  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;

  // One step: acc = (2*acc + bit*a) mod m, each partial kept below 2m
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, op_m}) ? (dbl - {1'b0, op_m}) : dbl;
    sum     = dbl_red + (mplier[WIDTH-1] ? {1'b0, op_a} : '0);
    sum_red = (sum >= {1'b0, op_m}) ? (sum - {1'b0, op_m}) : sum;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      op_a   <= multiplicand;
      op_m   <= modulus;
      mplier <= multiplier;
      acc    <= '0;
    end else if (busy) begin
      acc    <= sum_red[WIDTH-1:0];
      mplier <= {mplier[WIDTH-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

FILE: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: right-to-left binary modular exponentiation
// Computes base_value ^ exponent mod modulus with one shared multiplier.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high while it works.
// The base is first reduced by the modulus in one multiplier pass, then the
// exponent is scanned from its LSB: a set bit costs a multiply into the
// accumulator, and every bit up to the highest set bit costs a squaring. A
// zero exponent returns 1, also for a modulus of 1; a zero modulus returns 0
// with no multiplier pass, going straight to FINISH. The result sits in an
// output register, so the next item can be taken while it waits.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [OPERAND_WIDTH-1:0]            base_value,
  input  logic [OPERAND_WIDTH-1:0]            exponent,
  input  logic [OPERAND_WIDTH-1:0]            modulus,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [modexp_pkg::RESULT_WIDTH-1:0] power_result
);

  import modexp_pkg::*;

  logic [2:0]               state;
  logic [OPERAND_WIDTH-1:0] accumulator;
  logic [OPERAND_WIDTH-1:0] running_square;
  logic [OPERAND_WIDTH-1:0] exponent_left;
  logic [OPERAND_WIDTH-1:0] held_modulus;
  logic [OPERAND_WIDTH-1:0] result;

  logic                     mul_start;
  logic [OPERAND_WIDTH-1:0] mul_a;
  logic [OPERAND_WIDTH-1:0] mul_b;
  logic                     mul_done;
  logic [OPERAND_WIDTH-1:0] mul_product;

  assign in_stall = (state != ST_IDLE);

  // Shared modular multiplier
  modexp_mulmod #(
    .WIDTH (OPERAND_WIDTH)
  ) u_mulmod (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mul_a),
    .multiplier   (mul_b),
    .modulus      (held_modulus),
    .done         (mul_done),
    .product      (mul_product)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      // output register empties on a transfer unless FINISH reloads it
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            held_modulus  <= modulus;
            exponent_left <= exponent;
            accumulator   <= OPERAND_WIDTH'(1);
            if (modulus == '0) begin
              result <= '0;
              state  <= ST_FINISH;
            end else begin
              // base mod m as 1 * base mod m
              mul_a     <= OPERAND_WIDTH'(1);
              mul_b     <= base_value;
              mul_start <= 1'b1;
              state     <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            running_square <= mul_product;
            state          <= ST_STEP;
          end
        end
        ST_STEP: begin
          priority if (exponent_left == '0) begin
            result <= accumulator;
            state  <= ST_FINISH;
          end else if (exponent_left[0]) begin
            mul_a     <= accumulator;
            mul_b     <= running_square;
            mul_start <= 1'b1;
            state     <= ST_MUL_ACC;
          end else begin
            mul_a     <= running_square;
            mul_b     <= running_square;
            mul_start <= 1'b1;
            state     <= ST_SQUARE;
          end
        end
        ST_MUL_ACC: begin
          if (mul_done) begin
            accumulator <= mul_product;
            mul_a       <= running_square;
            mul_b       <= running_square;
            mul_start   <= 1'b1;
            state       <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mul_done) begin
            running_square <= mul_product;
            exponent_left  <= exponent_left >> 1;
            state          <= ST_STEP;
          end
        end
        ST_FINISH: begin
          // wait for the output register to be free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            power_result <= RESULT_WIDTH'(result);
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb: self-checking bench for modular exponentiation
// Sends base/exponent/modulus operands through the valid/stall input channel.
// Results are checked against known table values or a local right-to-left
// square-and-multiply predictor; a directed table covers the corner values.
// Random operands of mixed exponent length follow; channels idle at random.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  import modexp_pkg::*;

  localparam int OPERAND_WIDTH  = 31;
  localparam int RANDOM_ITEMS   = 300;
  localparam int QUIET_ITEMS    = 40;
  localparam int TAIL_CYCLES    = 64;
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int DIRECTED_COUNT = 21;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [RESULT_WIDTH-1:0]  result_t;

  localparam operand_t OPERAND_MAX = {OPERAND_WIDTH{1'b1}};

  // One row of the directed table; want is used only when known is set
  typedef struct packed {
    operand_t base_in;
    operand_t exponent_in;
    operand_t modulus_in;
    logic     known;
    result_t  want;
  } power_case_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     in_valid     = 1'b0;
  logic     in_stall;
  operand_t base_value   = '0;
  operand_t exponent     = '0;
  operand_t modulus      = '1;
  logic     out_valid;
  logic     out_stall    = 1'b0;
  result_t  power_result;

  result_t  expected_powers[$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       stall_left     = 0;
  bit       no_idle        = 1'b0;

  power_case_t directed_cases [DIRECTED_COUNT];

  modular_exponentiation #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .base_value  (base_value),
    .exponent    (exponent),
    .modulus     (modulus),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .power_result(power_result)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_powers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Square-and-multiply from the LSB; zero modulus gives zero
  function automatic result_t predict_power(operand_t b, operand_t e, operand_t m);
    bit [63:0] acc;
    bit [63:0] square;
    bit [63:0] m_wide;
    operand_t  bits_left;
    if (m == '0) begin
      return '0;
    end
    m_wide    = 64'(m);
    acc       = 64'd1;
    square    = 64'(b) % m_wide;
    bits_left = e;
    while (bits_left != '0) begin
      if (bits_left[0]) begin
        acc = (acc * square) % m_wide;
      end
      square    = (square * square) % m_wide;
      bits_left = bits_left >> 1;
    end
    return result_t'(acc);
  endfunction

  task automatic report_mismatch(string what, result_t got, result_t want);
    mismatch_count++;
    $display("[%0t] %s: power_result got 0x%08h want 0x%08h", $time, what, got, want);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_power(result_t got);
    result_t want;
    if (expected_powers.size() == 0) begin
      report_mismatch("result with nothing pending", got, '0);
    end else begin
      want = expected_powers.pop_front();
      if (got !== want) begin
        report_mismatch("wrong result", got, want);
      end
    end
  endtask

  // Result side: check transfers and stall in random bursts unless no_idle is set
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_power(power_result);
    end
    if (rst || no_idle) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    out_stall <= (stall_left > 0);
  end

  // Present one operand set and hold it until the transfer
  task automatic send_operands(operand_t b, operand_t e, operand_t m, logic known,
                               result_t want);
    in_valid   <= 1'b1;
    base_value <= b;
    exponent   <= e;
    modulus    <= m;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_powers.push_back(known ? want : predict_power(b, e, m));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    operand_t b;
    operand_t e;
    operand_t m;
    int       len;

    directed_cases = '{
      // exponent zero gives one, also for modulus one
      '{31'd0,        31'd0,        31'd1,        1'b1, 31'd1},
      '{31'd5,        31'd0,        31'd7,        1'b1, 31'd1},
      '{OPERAND_MAX,  31'd0,        OPERAND_MAX,  1'b1, 31'd1},
      // zero modulus returns zero with no scan
      '{31'd0,        31'd0,        31'd0,        1'b1, 31'd0},
      '{31'd7,        31'd5,        31'd0,        1'b1, 31'd0},
      '{OPERAND_MAX,  OPERAND_MAX,  31'd0,        1'b1, 31'd0},
      // small hand-checked values
      '{31'd0,        31'd5,        31'd13,       1'b1, 31'd0},
      '{31'd2,        31'd10,       31'd1000,     1'b1, 31'd24},
      '{31'd3,        31'd1,        31'd7,        1'b1, 31'd3},
      '{31'd10,       31'd1,        31'd7,        1'b1, 31'd3},
      '{OPERAND_MAX,  31'd1,        31'd1,        1'b1, 31'd0},
      // full-width extremes
      '{OPERAND_MAX,  OPERAND_MAX,  OPERAND_MAX,  1'b1, 31'd0},
      '{OPERAND_MAX,  OPERAND_MAX,  31'd2,        1'b1, 31'd1},
      '{31'd1,        OPERAND_MAX,  OPERAND_MAX,  1'b1, 31'd1},
      '{31'h7FFFFFFE, OPERAND_MAX,  OPERAND_MAX,  1'b1, 31'h7FFFFFFE},
      '{31'd2,        31'd30,       OPERAND_MAX,  1'b1, 31'h40000000},
      '{31'd2,        31'd31,       OPERAND_MAX,  1'b1, 31'd1},
      // predicted rows
      '{31'd2,        OPERAND_MAX,  31'h7FFFFFFD, 1'b0, 31'd0},
      '{31'd12345,    31'd6789,     31'd1000003,  1'b0, 31'd0},
      '{31'h2AAAAAAA, 31'h55555555, 31'h7FFFFFED, 1'b0, 31'd0},
      '{31'h55555555, 31'h2AAAAAAA, 31'h40000001, 1'b0, 31'd0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_cases[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_operands(directed_cases[i].base_in, directed_cases[i].exponent_in,
                    directed_cases[i].modulus_in, directed_cases[i].known,
                    directed_cases[i].want);
    end
    drain_results();

    // Random operands; exponent length varies to keep the run short
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        no_idle = 1'b1;
      end
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end

      case ($urandom_range(0, 5))
        0:       m = 31'd1;
        1:       m = operand_t'($urandom_range(2, 64));
        2:       m = OPERAND_MAX;
        default: m = operand_t'($urandom);
      endcase
      if (m == '0) begin
        m = 31'd1;
      end

      case ($urandom_range(0, 4))
        0:       b = '0;
        1:       b = operand_t'($urandom_range(1, 300));
        2:       b = m * operand_t'($urandom_range(1, 3));
        default: b = operand_t'($urandom);
      endcase

      len = ($urandom_range(0, 3) == 0) ? OPERAND_WIDTH : $urandom_range(0, OPERAND_WIDTH);
      e   = (len == 0) ? '0 : (operand_t'($urandom) & (OPERAND_MAX >> (OPERAND_WIDTH - len)));

      send_operands(b, e, m, 1'b0, '0);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
